[sv/clb_pkg.sv]
// clb_pkg: shared types and constants of the core load balancer
// used by clb_div and core_load_balancer; no dependencies
`timescale 1ns / 1ps

package clb_pkg;

  // default sizing of the balancer
  localparam int MAX_CORES_DEF   = 32;
  localparam int WEIGHT_BITS_DEF = 48;

  // fixed port widths
  localparam int CORE_W  = 5;
  localparam int DELTA_W = 32;
  localparam int DIV_W   = 64;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int CFG_W   = 6;

  // operation codes
  typedef enum logic [1:0] {
    OP_PLAN     = 2'd0,
    OP_BALANCE  = 2'd1,
    OP_SCHEDULE = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  // register indexes on the apb port
  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_ACTIVE = 2'd1;
  localparam logic [1:0] REG_NODE   = 2'd2;

  // register reset values
  localparam logic             ENABLE_RST = 1'b1;
  localparam logic [CFG_W-1:0] ACTIVE_RST = 6'd32;
  localparam logic [CFG_W-1:0] NODE_RST   = 6'd8;

  // divider handshake
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[sv/core_load_balancer.sv]
// core_load_balancer: work distribution table engine, top level
// depends on clb_pkg and clb_div
//
// usage: configure enable, active_cores and cores_per_node over the apb port
// (byte addresses 0, 4, 8) while the block is idle. An operation transaction
// is taken when start is high and busy is low; every transaction returns one
// result, shown for one cycle with out_valid high. The receiver cannot stall.
// sequence from accept to out_valid:
//   plan: the read-modify-write of the pending memory; no new plan is taken
//         until the last one has returned its result
//   clear: every pending entry zeroed, one pending entry zeroed a cycle
//   schedule: the divider for the draw modulo (skipped for a single bound or a
//         zero last bound), then one bound memory read per bound, up to n bounds
//   balance: one pending entry a cycle, the divider, then a bound write per core
//         and, for each core above average, the offload scan
//   disabled plan or balance: answered straight from idle
// reset: registers take their defaults and the pending memory is swept to zero,
// all 2^(2*clog2(MAX_CORES)) entries (1024 by default), with busy high.
`timescale 1ns / 1ps

module core_load_balancer #(
  parameter int MAX_CORES   = clb_pkg::MAX_CORES_DEF,
  parameter int WEIGHT_BITS = clb_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [clb_pkg::PADDR_W-1:0]         paddr,
  input  logic [clb_pkg::PDATA_W-1:0]         pwdata,
  output logic [clb_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_operation,
  input  logic [clb_pkg::CORE_W-1:0]          in_source_core,
  input  logic [clb_pkg::CORE_W-1:0]          in_target_core,
  input  logic signed [clb_pkg::DELTA_W-1:0]  in_delta,
  input  logic [clb_pkg::DIV_W-1:0]           in_random_value,
  output logic                                out_valid,
  output logic [clb_pkg::CORE_W-1:0]          out_scheduled_core,
  output logic                                out_not_managed
);
  import clb_pkg::*;

  localparam int WB       = WEIGHT_BITS;
  localparam int CW       = $clog2(MAX_CORES);
  localparam int AW       = $clog2(MAX_CORES + 1);
  localparam int PM_AW    = 2 * CW;
  localparam int PM_DEPTH = 1 << PM_AW;
  localparam int BM_W     = CW + WB;

  typedef enum logic [13:0] {
    S_IDLE      = 14'b00000000000001,
    S_CLR       = 14'b00000000000010,
    S_PLAN_WR   = 14'b00000000000100,
    S_BAL_SUM   = 14'b00000000001000,
    S_BAL_DRAIN = 14'b00000000010000,
    S_BAL_TOT   = 14'b00000000100000,
    S_BAL_DST   = 14'b00000001000000,
    S_BAL_DIV   = 14'b00000010000000,
    S_BAL_INIT  = 14'b00000100000000,
    S_OFF_SCAN  = 14'b00001000000000,
    S_OFF_APPLY = 14'b00010000000000,
    S_SCH_LAST  = 14'b00100000000000,
    S_SCH_DIV   = 14'b01000000000000,
    S_SCH_SCAN  = 14'b10000000000000
  } state_t;

  typedef logic signed [WB-1:0] weight_t;

  // configuration registers
  logic             enable_r;
  logic [CFG_W-1:0] active_r;
  logic [CFG_W-1:0] node_r;
  logic             cfg_wr;
  logic [AW-1:0]    act;
  logic [CFG_W-1:0] cpn;

  // control and working registers
  state_t              state_r, state_nxt;
  logic [PM_AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic                clr_rep_r, clr_rep_nxt;
  logic [CW-1:0]       src_r, src_nxt;
  logic [CW-1:0]       tgt_r, tgt_nxt;
  logic [CORE_W-1:0]   tgt_raw_r, tgt_raw_nxt;
  logic [DELTA_W-1:0]  delta_r, delta_nxt;
  logic [DIV_W-1:0]    rnd_r, rnd_nxt;
  logic [AW-1:0]       j_r, j_nxt;
  logic [AW-1:0]       c_r, c_nxt;
  logic                sum_v_r, sum_v_nxt;
  logic [CW-1:0]       sum_col_r, sum_col_nxt;
  logic [DIV_W-1:0]    tot_r, tot_nxt;
  weight_t             avg_r, avg_nxt;
  logic [CFG_W-1:0]    c_pos_r, c_pos_nxt;
  logic [CW-1:0]       c_node_r, c_node_nxt;
  logic [AW-1:0]       i_r, i_nxt;
  logic [CFG_W-1:0]    i_pos_r, i_pos_nxt;
  logic [CW-1:0]       i_node_r, i_node_nxt;
  logic                pass_r, pass_nxt;
  logic [MAX_CORES-1:0] elig_r, elig_nxt;
  weight_t             cdf_r, cdf_nxt;
  weight_t             wgt_r, wgt_nxt;
  weight_t             dl_r, dl_nxt;
  logic [CW-1:0]       cur_r, cur_nxt;
  logic [AW-1:0]       k_r, k_nxt;
  logic [AW-1:0]       n_r, n_nxt;
  logic [DIV_W-1:0]    seed_r, seed_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CORE_W-1:0]   out_core_r, out_core_nxt;
  logic                out_nm_r, out_nm_nxt;

  // per-core state
  weight_t       cw_r   [MAX_CORES];
  weight_t       cw_nxt [MAX_CORES];
  weight_t       load_r   [MAX_CORES];
  weight_t       load_nxt [MAX_CORES];
  logic [AW-1:0] cnt_r   [MAX_CORES];
  logic [AW-1:0] cnt_nxt [MAX_CORES];

  // memories
  logic [WB-1:0]    pm_mem [PM_DEPTH];
  logic [PM_AW-1:0] pm_addr;
  logic             pm_we;
  logic [WB-1:0]    pm_wdata;
  logic [WB-1:0]    pm_q;
  logic [BM_W-1:0]  bm_mem [PM_DEPTH];
  logic [PM_AW-1:0] bm_addr;
  logic             bm_we;
  logic [BM_W-1:0]  bm_wdata;
  logic [BM_W-1:0]  bm_q;

  // divider
  logic             div_start;
  logic [DIV_W-1:0] div_dvd;
  logic [DIV_W-1:0] div_dvs;
  div_stat_t        div_stat;
  logic [DIV_W-1:0] div_quo;
  logic [DIV_W-1:0] div_rem;

  // helpers
  logic             src_ok, tgt_ok;
  logic [CW-1:0]    in_src_idx, in_tgt_idx;
  logic             cand;
  weight_t          off_a, off_b, cdf_sum, bnd;
  logic [DIV_W-1:0] bnd64, last64, q_signed;
  logic             c_last;
  logic [AW-1:0]    c_inc;
  logic [CFG_W-1:0] c_pos_inc, i_pos_inc;
  logic [CW-1:0]    c_node_inc, i_node_inc;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= ENABLE_RST;
      active_r <= ACTIVE_RST;
      node_r   <= NODE_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ENABLE: enable_r <= pwdata[0];
        REG_ACTIVE: active_r <= pwdata[CFG_W-1:0];
        REG_NODE:   node_r   <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      REG_ENABLE: prdata = PDATA_W'(enable_r);
      REG_ACTIVE: prdata = PDATA_W'(active_r);
      REG_NODE:   prdata = PDATA_W'(node_r);
      default:    prdata = '0;
    endcase
  end

  // effective active count and node size
  always_comb begin
    if (active_r == '0) begin
      act = AW'(1);
    end else if (int'(active_r) > MAX_CORES) begin
      act = AW'(MAX_CORES);
    end else begin
      act = AW'(active_r);
    end
    cpn = (node_r == '0) ? CFG_W'(1) : node_r;
  end

  // ---------------- memories ----------------
  // pending matrix, entry {source, target}
  always_ff @(posedge clk) begin
    if (pm_we) begin
      pm_mem[pm_addr] <= pm_wdata;
    end
    pm_q <= pm_mem[pm_addr];
  end

  // bound table, entry {core, slot} holds {bound core, bound}
  always_ff @(posedge clk) begin
    if (bm_we) begin
      bm_mem[bm_addr] <= bm_wdata;
    end
    bm_q <= bm_mem[bm_addr];
  end

  clb_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // ---------------- helper terms ----------------
  always_comb begin
    src_ok     = int'(in_source_core) < MAX_CORES;
    tgt_ok     = int'(in_target_core) < MAX_CORES;
    in_src_idx = CW'(in_source_core);
    in_tgt_idx = CW'(in_target_core);
    // node position walkers for the outer core and the scan index
    c_inc      = c_r + 1'b1;
    c_last     = (c_r == act - 1'b1);
    c_pos_inc  = (c_pos_r == cpn - 1'b1) ? '0 : c_pos_r + 1'b1;
    c_node_inc = (c_pos_r == cpn - 1'b1) ? c_node_r + 1'b1 : c_node_r;
    i_pos_inc  = (i_pos_r == cpn - 1'b1) ? '0 : i_pos_r + 1'b1;
    i_node_inc = (i_pos_r == cpn - 1'b1) ? i_node_r + 1'b1 : i_node_r;
    cand       = elig_r[i_r[CW-1:0]] &&
                 (pass_r ? (i_node_r != c_node_r) : (i_node_r == c_node_r));
    off_a      = wgt_r - cdf_r;
    off_b      = avg_r - load_r[i_r[CW-1:0]];
    cdf_sum    = cdf_r + dl_r;
    bnd        = weight_t'(bm_q[WB-1:0]);
    bnd64      = DIV_W'(bnd);
    last64     = bnd64;
    q_signed   = tot_r[DIV_W-1] ? (~div_quo + 1'b1) : div_quo;
  end

  // ---------------- main sequencer ----------------
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_rep_nxt   = clr_rep_r;
    src_nxt       = src_r;
    tgt_nxt       = tgt_r;
    tgt_raw_nxt   = tgt_raw_r;
    delta_nxt     = delta_r;
    rnd_nxt       = rnd_r;
    j_nxt         = j_r;
    c_nxt         = c_r;
    sum_v_nxt     = sum_v_r;
    sum_col_nxt   = sum_col_r;
    tot_nxt       = tot_r;
    avg_nxt       = avg_r;
    c_pos_nxt     = c_pos_r;
    c_node_nxt    = c_node_r;
    i_nxt         = i_r;
    i_pos_nxt     = i_pos_r;
    i_node_nxt    = i_node_r;
    pass_nxt      = pass_r;
    elig_nxt      = elig_r;
    cdf_nxt       = cdf_r;
    wgt_nxt       = wgt_r;
    dl_nxt        = dl_r;
    cur_nxt       = cur_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    seed_nxt      = seed_r;
    out_valid_nxt = 1'b0;
    out_core_nxt  = out_core_r;
    out_nm_nxt    = out_nm_r;
    cw_nxt        = cw_r;
    load_nxt      = load_r;
    cnt_nxt       = cnt_r;
    pm_addr       = {src_r, tgt_r};
    pm_we         = 1'b0;
    pm_wdata      = '0;
    bm_addr       = {tgt_r, k_r[CW-1:0]};
    bm_we         = 1'b0;
    bm_wdata      = '0;
    div_start     = 1'b0;
    div_dvd       = rnd_r;
    div_dvs       = last64;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          src_nxt     = in_src_idx;
          tgt_nxt     = in_tgt_idx;
          tgt_raw_nxt = in_target_core;
          delta_nxt   = in_delta;
          rnd_nxt     = in_random_value;
          out_core_nxt = '0;
          out_nm_nxt   = 1'b0;
          case (op_t'(in_operation))
            OP_PLAN: begin
              if (enable_r && src_ok && tgt_ok) begin
                pm_addr   = {in_src_idx, in_tgt_idx};
                state_nxt = S_PLAN_WR;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            OP_BALANCE: begin
              if (enable_r) begin
                j_nxt     = '0;
                c_nxt     = '0;
                sum_v_nxt = 1'b0;
                for (int e = 0; e < MAX_CORES; e++) begin
                  cnt_nxt[e] = '0;
                end
                state_nxt = S_BAL_SUM;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            OP_SCHEDULE: begin
              if (!enable_r) begin
                out_valid_nxt = 1'b1;
                out_nm_nxt    = 1'b1;
              end else if (!tgt_ok || cnt_r[in_tgt_idx] == '0) begin
                out_valid_nxt = 1'b1;
                out_core_nxt  = in_target_core;
              end else begin
                n_nxt     = cnt_r[in_tgt_idx];
                bm_addr   = {in_tgt_idx, CW'(cnt_r[in_tgt_idx] - 1'b1)};
                state_nxt = S_SCH_LAST;
              end
            end
            OP_CLEAR: begin
              for (int e = 0; e < MAX_CORES; e++) begin
                cw_nxt[e]   = '0;
                load_nxt[e] = '0;
                cnt_nxt[e]  = '0;
              end
              clr_cnt_nxt = '0;
              clr_rep_nxt = 1'b1;
              state_nxt   = S_CLR;
            end
            default: ;
          endcase
        end
      end

      // zero one pending entry a cycle
      S_CLR: begin
        pm_addr     = clr_cnt_r;
        pm_we       = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          out_valid_nxt = clr_rep_r;
          state_nxt     = S_IDLE;
        end
      end

      // add the posted weight to the entry read last cycle
      S_PLAN_WR: begin
        pm_we         = 1'b1;
        pm_wdata      = pm_q + WB'(signed'(delta_r));
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      // fold the pending matrix into the core weights, zeroing as we go
      S_BAL_SUM: begin
        pm_addr     = {j_r[CW-1:0], c_r[CW-1:0]};
        pm_we       = 1'b1;
        sum_v_nxt   = 1'b1;
        sum_col_nxt = c_r[CW-1:0];
        if (sum_v_r) begin
          cw_nxt[sum_col_r] = cw_r[sum_col_r] + pm_q;
        end
        if (j_r == act - 1'b1) begin
          j_nxt = '0;
          if (c_last) begin
            state_nxt = S_BAL_DRAIN;
          end else begin
            c_nxt = c_inc;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end

      S_BAL_DRAIN: begin
        cw_nxt[sum_col_r] = cw_r[sum_col_r] + pm_q;
        sum_v_nxt = 1'b0;
        c_nxt     = '0;
        tot_nxt   = '0;
        state_nxt = S_BAL_TOT;
      end

      // total of the weights, loads start at the weights
      S_BAL_TOT: begin
        tot_nxt = tot_r + DIV_W'(cw_r[c_r[CW-1:0]]);
        load_nxt[c_r[CW-1:0]] = cw_r[c_r[CW-1:0]];
        if (c_last) begin
          state_nxt = S_BAL_DST;
        end else begin
          c_nxt = c_inc;
        end
      end

      // divide the magnitude of the total by the active count
      S_BAL_DST: begin
        div_start = 1'b1;
        div_dvd   = tot_r[DIV_W-1] ? (~tot_r + 1'b1) : tot_r;
        div_dvs   = DIV_W'(act);
        state_nxt = S_BAL_DIV;
      end

      S_BAL_DIV: begin
        if (div_stat.done) begin
          avg_nxt    = WB'(q_signed);
          c_nxt      = '0;
          c_pos_nxt  = '0;
          c_node_nxt = '0;
          state_nxt  = S_BAL_INIT;
        end
      end

      // first bound of a core, cap at the average if above it
      S_BAL_INIT: begin
        bm_we   = 1'b1;
        bm_addr = {c_r[CW-1:0], CW'(0)};
        cnt_nxt[c_r[CW-1:0]] = AW'(1);
        if (cw_r[c_r[CW-1:0]] > avg_r) begin
          bm_wdata = {c_r[CW-1:0], avg_r};
          load_nxt[c_r[CW-1:0]] = avg_r;
          cdf_nxt = avg_r;
          wgt_nxt = cw_r[c_r[CW-1:0]];
          for (int e = 0; e < MAX_CORES; e++) begin
            elig_nxt[e] = (e < int'(act)) && (CW'(e) != c_r[CW-1:0]) &&
                          (load_r[e] < avg_r);
          end
          i_nxt      = '0;
          i_pos_nxt  = '0;
          i_node_nxt = '0;
          pass_nxt   = 1'b0;
          state_nxt  = S_OFF_SCAN;
        end else begin
          bm_wdata = {c_r[CW-1:0], cw_r[c_r[CW-1:0]]};
          if (c_last) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            c_nxt      = c_inc;
            c_pos_nxt  = c_pos_inc;
            c_node_nxt = c_node_inc;
          end
        end
      end

      // walk same-node receivers, then the other nodes
      S_OFF_SCAN: begin
        if (i_r == act) begin
          if (!pass_r) begin
            pass_nxt   = 1'b1;
            i_nxt      = '0;
            i_pos_nxt  = '0;
            i_node_nxt = '0;
          end else if (c_last) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            c_nxt      = c_inc;
            c_pos_nxt  = c_pos_inc;
            c_node_nxt = c_node_inc;
            state_nxt  = S_BAL_INIT;
          end
        end else if (cand) begin
          if (!(cdf_r < wgt_r)) begin
            if (c_last) begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              c_nxt      = c_inc;
              c_pos_nxt  = c_pos_inc;
              c_node_nxt = c_node_inc;
              state_nxt  = S_BAL_INIT;
            end
          end else begin
            dl_nxt    = (off_a < off_b) ? off_a : off_b;
            cur_nxt   = i_r[CW-1:0];
            state_nxt = S_OFF_APPLY;
          end
        end else begin
          i_nxt      = i_r + 1'b1;
          i_pos_nxt  = i_pos_inc;
          i_node_nxt = i_node_inc;
        end
      end

      // hand one share to the receiver and record the bound
      S_OFF_APPLY: begin
        cdf_nxt           = cdf_sum;
        load_nxt[cur_r]   = load_r[cur_r] + dl_r;
        bm_we             = 1'b1;
        bm_addr           = {c_r[CW-1:0], cnt_r[c_r[CW-1:0]][CW-1:0]};
        bm_wdata          = {cur_r, cdf_sum};
        cnt_nxt[c_r[CW-1:0]] = cnt_r[c_r[CW-1:0]] + 1'b1;
        i_nxt      = i_r + 1'b1;
        i_pos_nxt  = i_pos_inc;
        i_node_nxt = i_node_inc;
        state_nxt  = S_OFF_SCAN;
      end

      // last bound of the queried core is in bm_q
      S_SCH_LAST: begin
        if (n_r == AW'(1)) begin
          out_valid_nxt = 1'b1;
          out_core_nxt  = CORE_W'(bm_q[BM_W-1:WB]);
          state_nxt     = S_IDLE;
        end else if (last64 == '0) begin
          seed_nxt  = '0;
          k_nxt     = '0;
          bm_addr   = {tgt_r, CW'(0)};
          state_nxt = S_SCH_SCAN;
        end else begin
          div_start = 1'b1;
          state_nxt = S_SCH_DIV;
        end
      end

      S_SCH_DIV: begin
        if (div_stat.done) begin
          seed_nxt  = div_rem;
          k_nxt     = '0;
          bm_addr   = {tgt_r, CW'(0)};
          state_nxt = S_SCH_SCAN;
        end
      end

      // first bound above the draw picks the core, else the last bound
      S_SCH_SCAN: begin
        if (bnd64 > seed_r || k_r == n_r - 1'b1) begin
          out_valid_nxt = 1'b1;
          out_core_nxt  = CORE_W'(bm_q[BM_W-1:WB]);
          state_nxt     = S_IDLE;
        end else begin
          k_nxt   = k_r + 1'b1;
          bm_addr = {tgt_r, CW'(k_r + 1'b1)};
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state and per-core tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      clr_rep_r   <= 1'b0;
      sum_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_core_r  <= '0;
      out_nm_r    <= 1'b0;
      tgt_raw_r   <= '0;
      for (int e = 0; e < MAX_CORES; e++) begin
        cw_r[e]   <= '0;
        load_r[e] <= '0;
        cnt_r[e]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_rep_r   <= clr_rep_nxt;
      sum_v_r     <= sum_v_nxt;
      out_valid_r <= out_valid_nxt;
      out_core_r  <= out_core_nxt;
      out_nm_r    <= out_nm_nxt;
      tgt_raw_r   <= tgt_raw_nxt;
      cw_r        <= cw_nxt;
      load_r      <= load_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    src_r     <= src_nxt;
    tgt_r     <= tgt_nxt;
    delta_r   <= delta_nxt;
    rnd_r     <= rnd_nxt;
    j_r       <= j_nxt;
    c_r       <= c_nxt;
    sum_col_r <= sum_col_nxt;
    tot_r     <= tot_nxt;
    avg_r     <= avg_nxt;
    c_pos_r   <= c_pos_nxt;
    c_node_r  <= c_node_nxt;
    i_r       <= i_nxt;
    i_pos_r   <= i_pos_nxt;
    i_node_r  <= i_node_nxt;
    pass_r    <= pass_nxt;
    elig_r    <= elig_nxt;
    cdf_r     <= cdf_nxt;
    wgt_r     <= wgt_nxt;
    dl_r      <= dl_nxt;
    cur_r     <= cur_nxt;
    k_r       <= k_nxt;
    n_r       <= n_nxt;
    seed_r    <= seed_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_scheduled_core = out_core_r;
  assign out_not_managed    = out_nm_r;

  // ---------------- assertions ----------------
  // a result follows either an accepted transaction or a busy cycle
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result without a transaction");

  // the disabled-schedule answer never carries a core
  a_nm_core: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_not_managed |-> out_scheduled_core == '0)
    else $error("not_managed with nonzero core");

  // the divider is only started when free
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  // the raw target is only latched on accept
  a_tgt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    busy && $past(busy) |-> $stable(tgt_raw_r))
    else $error("target changed during a transaction");

endmodule

[sv/clb_div.sv]
// clb_div: 64-bit unsigned restoring divider, one quotient bit per cycle
// depends on clb_pkg
`timescale 1ns / 1ps

module clb_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [clb_pkg::DIV_W-1:0]  dividend,
  input  logic [clb_pkg::DIV_W-1:0]  divisor,
  output clb_pkg::div_stat_t         stat,
  output logic [clb_pkg::DIV_W-1:0]  quotient,
  output logic [clb_pkg::DIV_W-1:0]  remainder
);
  import clb_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DIV_W:0]   shifted;
  logic [DIV_W+1:0] trial;

  // one shift and trial subtract per cycle
  always_comb begin
    shifted  = {rem_r, quo_r[DIV_W-1]};
    trial    = {1'b0, shifted} - {2'b00, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DIV_W+1]) begin
        rem_nxt = trial[DIV_W-1:0];
      end else begin
        rem_nxt = shifted[DIV_W-1:0];
      end
      quo_nxt = {quo_r[DIV_W-2:0], !trial[DIV_W+1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
